// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the store's checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define EKS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, during reset too.
`define EKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/eks_pkg.sv
// ---------------------------------------------------------------------------
// eks_pkg
// Field widths, opcodes and status codes of the expiring order-statistic store.
// ---------------------------------------------------------------------------
package eks_pkg;

  localparam int unsigned FW     = 31;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned ENT_W  = 3 * FW;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_FOUND   = 3'd0;
  localparam logic [ST_W-1:0] ST_NORANK  = 3'd1;
  localparam logic [ST_W-1:0] ST_INSERT  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

  typedef logic [FW-1:0] fld_t;

endpackage

// File: src/eks_ram.sv
// ---------------------------------------------------------------------------
// eks_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module eks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: src/expiring_kth_smallest_store.sv
// ---------------------------------------------------------------------------
// expiring_kth_smallest_store
// Bounded store of timed values with expiry, insert, rank query and clear.
// ---------------------------------------------------------------------------
// Each item but a clear first sweeps all CAPACITY slots to drop expired
// entries, reading one slot per cycle from the entry RAM. An insert then
// scans the slots again for a repeated pair and the lowest free slot. A query
// binary-searches the value range in exactly 31 steps, each of which picks
// the midpoint and then makes one counting scan of the slots. A clear empties
// the store at once and skips the sweep.
// The single RAM read port and one shared comparator serialize this work; the
// block takes one item at a time and is ready again once its result is
// registered on the output.
module expiring_kth_smallest_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // now_time[30:0], item_value[61:31], expiry_time[92:62], rank_k[123:93]
  input  logic [127:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // found_value[30:0]
  output logic [31:0]   m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]    m_axis_tuser_o
);

  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned FW    = eks_pkg::FW;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_INSFIN = 3'd3;
  localparam logic [2:0] S_QMID   = 3'd4;
  localparam logic [2:0] S_QSCAN  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [CAPACITY-1:0]    live_q, live_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   pv_q, pv_d;
  logic [IW-1:0]          pidx_q, pidx_d;

  logic [eks_pkg::OP_W-1:0] op_q, op_d;
  eks_pkg::fld_t          now_q, now_d, val_q, val_d, exp_q, exp_d, k_q, k_d;

  logic                   dup_q, dup_d, free_ok_q, free_ok_d;
  logic [IW-1:0]          dup_idx_q, dup_idx_d, free_idx_q, free_idx_d;
  eks_pkg::fld_t          dup_exp_q, dup_exp_d;

  eks_pkg::fld_t          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]          le_q, le_d;

  logic [eks_pkg::ST_W-1:0] pend_st_q, pend_st_d, res_st_q, res_st_d;
  eks_pkg::fld_t          pend_val_q, pend_val_d, res_val_q, res_val_d;
  logic                   res_valid_q, res_valid_d;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [eks_pkg::ENT_W-1:0] wr_data, rd_data;
  eks_pkg::fld_t          rd_val, rd_stamp, rd_exp;

  eks_pkg::fld_t          cmp_a, cmp_b;
  logic                   cmp_lt;
  logic                   issue, scan_end, cur_live;
  logic [FW:0]            mid_sum;

  assign rd_val   = rd_data[FW-1:0];
  assign rd_stamp = rd_data[2*FW-1:FW];
  assign rd_exp   = rd_data[3*FW-1:2*FW];

  eks_ram #(
    .WIDTH(eks_pkg::ENT_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(cnt_q[IW-1:0]),
    .rd_data_o(rd_data)
  );

  always_comb begin
    unique case (state_q)
      S_SWEEP: begin
        cmp_a = rd_exp;
        cmp_b = now_q;
      end
      S_INSFIN: begin
        cmp_a = exp_q;
        cmp_b = dup_exp_q;
      end
      default: begin
        cmp_a = mid_q;
        cmp_b = rd_val;
      end
    endcase
  end

  assign cmp_lt   = cmp_a < cmp_b;
  assign issue    = cnt_q != CAP_CNT;
  assign scan_end = !issue && !pv_q;
  assign cur_live = live_q[pidx_q];
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = {1'b0, res_val_q};
  assign m_axis_tuser_o  = res_st_q;

  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    op_d        = op_q;
    now_d       = now_q;
    val_d       = val_q;
    exp_d       = exp_q;
    k_d         = k_q;
    dup_d       = dup_q;
    dup_idx_d   = dup_idx_q;
    dup_exp_d   = dup_exp_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    le_d        = le_q;
    pend_st_d   = pend_st_q;
    pend_val_d  = pend_val_q;
    res_st_d    = res_st_q;
    res_val_d   = res_val_q;
    res_valid_d = res_valid_q && !m_axis_tready_i;
    wr_en       = 1'b0;
    wr_addr     = free_idx_q;
    wr_data     = {exp_q, now_q, val_q};

    if ((state_q == S_SWEEP || state_q == S_INS || state_q == S_QSCAN) && issue) begin
      cnt_d  = cnt_q + 1'b1;
      pv_d   = 1'b1;
      pidx_d = cnt_q[IW-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d  = s_axis_tuser_i;
          now_d = s_axis_tdata_i[FW-1:0];
          val_d = s_axis_tdata_i[2*FW-1:FW];
          exp_d = s_axis_tdata_i[3*FW-1:2*FW];
          k_d   = s_axis_tdata_i[4*FW-1:3*FW];
          cnt_d = '0;
          if (s_axis_tuser_i == eks_pkg::OP_CLEAR) begin
            live_d     = '0;
            count_d    = '0;
            pend_st_d  = eks_pkg::ST_CLEARED;
            pend_val_d = '0;
            state_d    = S_DONE;
          end else begin
            state_d = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (pv_q && cur_live && cmp_lt) begin
          live_d[pidx_q] = 1'b0;
          count_d        = count_q - 1'b1;
        end
        if (scan_end) begin
          cnt_d      = '0;
          pend_val_d = '0;
          if (op_q == eks_pkg::OP_INSERT) begin
            dup_d     = 1'b0;
            free_ok_d = 1'b0;
            state_d   = S_INS;
          end else if (op_q == eks_pkg::OP_QUERY && k_q != '0
                       && k_q <= FW'(count_q)) begin
            lo_d    = '0;
            hi_d    = '1;
            state_d = S_QMID;
          end else begin
            pend_st_d = eks_pkg::ST_NORANK;
            state_d   = S_DONE;
          end
        end
      end
      S_INS: begin
        if (pv_q && cur_live && rd_val == val_q && rd_stamp == now_q) begin
          dup_d     = 1'b1;
          dup_idx_d = pidx_q;
          dup_exp_d = rd_exp;
          state_d   = S_INSFIN;
        end else begin
          if (pv_q && !cur_live && !free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = pidx_q;
          end
          if (scan_end) begin
            state_d = S_INSFIN;
          end
        end
      end
      S_INSFIN: begin
        pend_st_d = eks_pkg::ST_INSERT;
        state_d   = S_DONE;
        if (dup_q) begin
          wr_en   = 1'b1;
          wr_addr = dup_idx_q;
          wr_data = {(cmp_lt ? exp_q : dup_exp_q), now_q, val_q};
        end else if (free_ok_q) begin
          wr_en              = 1'b1;
          live_d[free_idx_q] = 1'b1;
          count_d            = count_q + 1'b1;
        end else begin
          pend_st_d = eks_pkg::ST_FULL;
        end
      end
      S_QMID: begin
        if (lo_q == hi_q) begin
          pend_st_d  = eks_pkg::ST_FOUND;
          pend_val_d = lo_q;
          state_d    = S_DONE;
        end else begin
          mid_d   = mid_sum[FW:1];
          cnt_d   = '0;
          le_d    = '0;
          state_d = S_QSCAN;
        end
      end
      S_QSCAN: begin
        if (pv_q && cur_live && !cmp_lt) begin
          le_d = le_q + 1'b1;
        end
        if (scan_end) begin
          if (FW'(le_q) >= k_q) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q + 1'b1;
          end
          state_d = S_QMID;
        end
      end
      S_DONE: begin
        if (!res_valid_q || m_axis_tready_i) begin
          res_valid_d = 1'b1;
          res_st_d    = pend_st_q;
          res_val_d   = pend_val_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      count_q     <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      dup_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      dup_q       <= dup_d;
      free_ok_q   <= free_ok_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    op_q       <= op_d;
    now_q      <= now_d;
    val_q      <= val_d;
    exp_q      <= exp_d;
    k_q        <= k_d;
    dup_idx_q  <= dup_idx_d;
    dup_exp_q  <= dup_exp_d;
    free_idx_q <= free_idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    le_q       <= le_d;
    pend_st_q  <= pend_st_d;
    pend_val_q <= pend_val_d;
    res_st_q   <= res_st_d;
    res_val_q  <= res_val_d;
  end

endmodule

// File: src/eks_checker.sv
// ---------------------------------------------------------------------------
// eks_checker
// Port-level checks of the expiring order-statistic store, bound to its top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module eks_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [127:0] s_axis_tdata_i,
  input logic [1:0]   s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [31:0]  m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o
);

  `EKS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `EKS_ASSERT(a_status_range, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tuser_o <= eks_pkg::ST_CLEARED, "status code out of range")
  `EKS_ASSERT(a_found_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o != eks_pkg::ST_FOUND |-> m_axis_tdata_o == 32'd0, "found value not zero")
  `EKS_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "ready right after accept")
  `EKS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

endmodule

bind expiring_kth_smallest_store eks_checker u_eks_checker (.*);
